[sv/kbd6_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// kbd6_pkg
// Shared types and code points for the six-key keyboard report tracker.
// ============================================================================
package kbd6_pkg;

    // Number of key slots carried in one report word.
    localparam int REPORT_SLOTS = 6;

    // Usage code boundaries.
    localparam logic [7:0] MOD_FIRST    = 8'hE0;
    localparam logic [7:0] MOD_END      = 8'hE8;
    localparam logic [7:0] MOD_LAST     = MOD_END - 8'd1;
    localparam logic [7:0] KEY_FIRST    = 8'h01;
    localparam logic [7:0] KEY_END      = 8'hA5;
    localparam logic [7:0] KEY_LAST     = KEY_END - 8'd1;
    localparam logic [7:0] CODED_OFFSET = 8'h88;
    localparam logic [7:0] CODED_MOD    = 8'h80;

    // Key event operations.
    typedef enum logic [2:0] {
        OP_RAW_PRESS     = 3'd0,
        OP_RAW_RELEASE   = 3'd1,
        OP_CODED_PRESS   = 3'd2,
        OP_CODED_RELEASE = 3'd3,
        OP_RELEASE_ALL   = 3'd4
    } op_t;

    // Status flags that travel with each report.
    typedef struct packed {
        logic accepted;
        logic sent;
    } report_status_t;

endpackage

[sv/kbd6_slot_match.sv]
`timescale 1ns / 1ps
// ============================================================================
// kbd6_slot_match
// Parallel compare of a usage code against every key slot, with a priority
// pick of the lowest empty slot.
// ============================================================================
module kbd6_slot_match #(
    parameter int SLOT_COUNT = 6
) (
    input  logic [7:0]            slots [SLOT_COUNT],
    input  logic [7:0]            code,
    output logic [SLOT_COUNT-1:0] match,
    output logic [SLOT_COUNT-1:0] first_free,
    output logic                  present,
    output logic                  any_free
);

    logic [SLOT_COUNT-1:0] empty;

    // One comparator pair per slot.
    always_comb
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            match[i] = (slots[i] == code);
            empty[i] = (slots[i] == 8'h00);
        end
    end

    // The lowest set bit of the empty mask marks the slot to fill.
    assign first_free = empty & (~empty + SLOT_COUNT'(1));
    assign present    = |match;
    assign any_free   = |empty;

endmodule

[sv/kbd6_report_update.sv]
`timescale 1ns / 1ps
// ============================================================================
// kbd6_report_update
// Works out the next modifier byte, key slots and status flags for one key
// event against the current report.
// ============================================================================
module kbd6_report_update #(
    parameter int SLOT_COUNT = 6
) (
    input  logic [2:0]              op,
    input  logic [7:0]              code,
    input  logic [7:0]              mods_in,
    input  logic [7:0]              slots_in  [SLOT_COUNT],
    output logic [7:0]              mods_out,
    output logic [7:0]              slots_out [SLOT_COUNT],
    output kbd6_pkg::report_status_t status
);

    logic [7:0]            raw_code;
    logic [SLOT_COUNT-1:0] match;
    logic [SLOT_COUNT-1:0] first_free;
    logic                  present;
    logic                  any_free;
    logic                  raw_go;
    logic                  press;
    logic                  is_mod;
    logic                  is_key;

    // Coded events above the modifier block map onto raw codes.
    always_comb
    begin
        case (op)
            kbd6_pkg::OP_CODED_PRESS,
            kbd6_pkg::OP_CODED_RELEASE: raw_code = code - kbd6_pkg::CODED_OFFSET;
            default:                    raw_code = code;
        endcase
    end

    assign is_mod = raw_code inside {[kbd6_pkg::MOD_FIRST : kbd6_pkg::MOD_LAST]};
    assign is_key = raw_code inside {[kbd6_pkg::KEY_FIRST : kbd6_pkg::KEY_LAST]};

    kbd6_slot_match #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_slot_match (
        .slots      (slots_in),
        .code       (raw_code),
        .match      (match),
        .first_free (first_free),
        .present    (present),
        .any_free   (any_free)
    );

    // Event decode and report update.
    always_comb
    begin
        mods_out  = mods_in;
        slots_out = slots_in;
        status    = '0;
        raw_go    = 1'b0;
        press     = 1'b0;

        case (op)
            kbd6_pkg::OP_RAW_PRESS:
            begin
                raw_go = 1'b1;
                press  = 1'b1;
            end
            kbd6_pkg::OP_RAW_RELEASE:
            begin
                raw_go = 1'b1;
            end
            kbd6_pkg::OP_CODED_PRESS:
            begin
                if (code >= kbd6_pkg::CODED_OFFSET)
                begin
                    raw_go = 1'b1;
                    press  = 1'b1;
                end
                else if (code >= kbd6_pkg::CODED_MOD)
                begin
                    // The modifier is now held, so the report always goes out.
                    mods_out[code[2:0]] = 1'b1;
                    status = '{accepted: 1'b1, sent: 1'b1};
                end
            end
            kbd6_pkg::OP_CODED_RELEASE:
            begin
                if (code >= kbd6_pkg::CODED_OFFSET)
                begin
                    raw_go = 1'b1;
                end
                else if (code >= kbd6_pkg::CODED_MOD)
                begin
                    mods_out[code[2:0]] = 1'b0;
                    status = '{accepted: 1'b1, sent: 1'b1};
                end
            end
            kbd6_pkg::OP_RELEASE_ALL:
            begin
                mods_out = 8'h00;
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    slots_out[i] = 8'h00;
                end
                status = '{accepted: 1'b1, sent: 1'b1};
            end
            default:
            begin
                status = '0;
            end
        endcase

        // Raw usage code handling.
        if (raw_go)
        begin
            if (is_mod)
            begin
                mods_out[raw_code[2:0]] = press;
                status = '{accepted: 1'b1, sent: 1'b1};
            end
            else if (is_key)
            begin
                if (!press)
                begin
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        if (match[i])
                        begin
                            slots_out[i] = 8'h00;
                        end
                    end
                    status = '{accepted: 1'b1, sent: 1'b1};
                end
                else if (present)
                begin
                    status = '{accepted: 1'b1, sent: 1'b1};
                end
                else if (any_free)
                begin
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        if (first_free[i])
                        begin
                            slots_out[i] = raw_code;
                        end
                    end
                    status = '{accepted: 1'b1, sent: 1'b1};
                end
                else
                begin
                    // All slots taken: the press is refused.
                    status = '0;
                end
            end
            else
            begin
                // Out-of-range code: a press only reports while a modifier is held.
                if (!press || (mods_in != 8'h00))
                begin
                    status = '{accepted: 1'b1, sent: 1'b1};
                end
            end
        end
    end

endmodule

[sv/keyboard_six_key_report_tracker_core.sv]
`timescale 1ns / 1ps
// ============================================================================
// keyboard_six_key_report_tracker_core
// Keeps a boot keyboard report (modifier byte and key slots) and returns the
// updated report with its status for every key event word.
// ============================================================================
//
//  Channel  | Direction | tdata                          | tuser
//  ---------+-----------+--------------------------------+-----------------------
//  s_axis   | in        | key_code                       | operation
//  m_axis   | out       | modifier_bits, slot_zero..five | report_sent, accepted
//
//  One word is taken every cycle while m_axis does not stall; each word
//  passes through the input register, the single pass of slot compares and
//  first-free pick, and the result register, which offers its result word.
//  Reset clears the modifier byte, every key slot and both valid flags.
//  A stall on m_axis holds the result register; the input register still
//  takes one more word and then holds it until the result moves on.
//
module keyboard_six_key_report_tracker_core #(
    parameter int SLOT_COUNT = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] key_code
    input  logic [2:0]  s_axis_tuser,   // [2:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [7:0] modifier_bits, [15:8] slot_zero,
                                        // [23:16] slot_one, [31:24] slot_two,
                                        // [39:32] slot_three, [47:40] slot_four,
                                        // [55:48] slot_five
    output logic [1:0]  m_axis_tuser    // [0] report_sent, [1] accepted
);

    logic                     in_valid_reg;
    logic [2:0]               in_op_reg;
    logic [7:0]               in_code_reg;
    logic [7:0]               mods_reg;
    logic [7:0]               slots_reg     [SLOT_COUNT];
    logic [7:0]               mods_next;
    logic [7:0]               slots_next    [SLOT_COUNT];
    kbd6_pkg::report_status_t status_next;
    logic                     out_valid_reg;
    logic [7:0]               out_mods_reg;
    logic [7:0]               out_slots_reg [SLOT_COUNT];
    kbd6_pkg::report_status_t out_status_reg;
    logic                     advance;
    logic [7:0]               report_slot   [kbd6_pkg::REPORT_SLOTS];

    // The input word moves on when the result register is free or draining.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_op_reg   <= s_axis_tuser;
            in_code_reg <= s_axis_tdata;
        end
    end

    kbd6_report_update #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_report_update (
        .op        (in_op_reg),
        .code      (in_code_reg),
        .mods_in   (mods_reg),
        .slots_in  (slots_reg),
        .mods_out  (mods_next),
        .slots_out (slots_next),
        .status    (status_next)
    );

    // Report state, committed when the word moves to the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mods_reg <= 8'h00;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slots_reg[i] <= 8'h00;
            end
        end
        else if (advance)
        begin
            mods_reg  <= mods_next;
            slots_reg <= slots_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_mods_reg   <= mods_next;
            out_slots_reg  <= slots_next;
            out_status_reg <= status_next;
        end
    end

    // Slots beyond the configured count read as empty.
    for (genvar j = 0; j < kbd6_pkg::REPORT_SLOTS; j++)
    begin : g_report_slot
        if (j < SLOT_COUNT)
        begin : g_used
            assign report_slot[j] = out_slots_reg[j];
        end
        else
        begin : g_unused
            assign report_slot[j] = 8'h00;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {report_slot[5], report_slot[4], report_slot[3],
                            report_slot[2], report_slot[1], report_slot[0],
                            out_mods_reg};
    assign m_axis_tuser  = {out_status_reg.accepted, out_status_reg.sent};

endmodule

[sv/kbd6_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// kbd6_checker
// Port-level checks on the report tracker, bound to the top level.
// ============================================================================
module kbd6_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // True when two non-empty slots of a report hold the same code.
    function automatic logic has_duplicate(input logic [55:0] data);
        logic dup;
        dup = 1'b0;
        for (int a = 1; a < 7; a++)
        begin
            for (int b = a + 1; b < 7; b++)
            begin
                if ((data[a*8 +: 8] != 8'h00) && (data[a*8 +: 8] == data[b*8 +: 8]))
                begin
                    dup = 1'b1;
                end
            end
        end
        return dup;
    endfunction

    // A stalled result word holds still.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("Result word changed while stalled.");

    // A report goes out exactly when the event is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] == m_axis_tuser[1]))
    else $error("Report sent flag disagrees with accepted flag.");

    // Key slots only ever hold keyboard usage codes.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[15:8]  < kbd6_pkg::KEY_END) &&
            (m_axis_tdata[23:16] < kbd6_pkg::KEY_END) &&
            (m_axis_tdata[31:24] < kbd6_pkg::KEY_END) &&
            (m_axis_tdata[39:32] < kbd6_pkg::KEY_END) &&
            (m_axis_tdata[47:40] < kbd6_pkg::KEY_END) &&
            (m_axis_tdata[55:48] < kbd6_pkg::KEY_END))
    else $error("Key slot holds a code outside the key range.");

    // A code is never held in two slots at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !has_duplicate(m_axis_tdata))
    else $error("Same key code held in two slots.");

endmodule

bind keyboard_six_key_report_tracker_core kbd6_checker u_kbd6_checker (.*);
